// File: src/ncc_pkg.sv
// ----------------------------------------------------------------------------
// ncc_pkg: shared types and constants for the nearest-centroid classifier
// Request codes, payload structs, memory geometry.
// ----------------------------------------------------------------------------
package ncc_pkg;
    localparam int NUM_CLASSES  = 4;
    localparam int NUM_CHANNELS = 5;
    localparam int CLS_W  = 2;
    localparam int SMP_W  = 14;
    localparam int CNT_W  = 16;
    localparam int OUT_W  = 3;
    localparam int CH_W   = 3;
    localparam int ADDR_W = 5;
    localparam int DEPTH  = NUM_CLASSES * NUM_CHANNELS;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [OUT_W-1:0] NO_CLASS = OUT_W'(NUM_CLASSES);

    localparam logic [1:0] REQ_LEARN = 2'd0;
    localparam logic [1:0] REQ_ASK   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [CLS_W-1:0] class_index;
        logic [SMP_W-1:0] sample_ch0;
        logic [SMP_W-1:0] sample_ch1;
        logic [SMP_W-1:0] sample_ch2;
        logic [SMP_W-1:0] sample_ch3;
        logic [SMP_W-1:0] sample_ch4;
    } t_req;

    typedef struct packed {
        logic [OUT_W-1:0] nearest_ch0;
        logic [OUT_W-1:0] nearest_ch1;
        logic [OUT_W-1:0] nearest_ch2;
        logic [OUT_W-1:0] nearest_ch3;
        logic [OUT_W-1:0] nearest_ch4;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_LRD, S_LWAIT, S_LDIV, S_LWR,
        S_ARD, S_AWAIT, S_ACMP, S_ADONE
    } t_state;

    function automatic logic [SMP_W-1:0] sample_sel(input t_req r, input logic [CH_W-1:0] c);
        logic [SMP_W-1:0] s;
        case (c)
            3'd0: s = r.sample_ch0;
            3'd1: s = r.sample_ch1;
            3'd2: s = r.sample_ch2;
            3'd3: s = r.sample_ch3;
            3'd4: s = r.sample_ch4;
            default: s = '0;
        endcase
        return s;
    endfunction
endpackage

// File: src/ncc_div.sv
// ----------------------------------------------------------------------------
// ncc_div: restoring divider, one quotient bit per cycle
// Divides a 30-bit dividend by a 16-bit divisor; quotient low 14 bits kept.
// ----------------------------------------------------------------------------
module ncc_div import ncc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [29:0]      i_num,
    input  logic [CNT_W-1:0] i_den,
    output logic             o_done,
    output logic [SMP_W-1:0] o_quo
);
    logic [29:0] r_num, n_num;
    logic [CNT_W:0] r_rem, n_rem;
    logic [CNT_W-1:0] r_den;
    logic [4:0] r_cnt;
    logic r_busy;
    logic [CNT_W+1:0] trial;

    always_comb begin
        trial = {r_rem, r_num[29]} - {2'b0, r_den};
        n_num = {r_num[28:0], ~trial[CNT_W+1]};
        n_rem = trial[CNT_W+1] ? {r_rem[CNT_W-1:0], r_num[29]} : trial[CNT_W:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd30;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_quo = r_num[SMP_W-1:0];
endmodule

// File: src/nearest_centroid_channel_classifier.sv
// ----------------------------------------------------------------------------
// nearest_centroid_channel_classifier: per-channel nearest-mean classifier
// Means kept in one synchronous RAM; counts in flip-flops.
// ----------------------------------------------------------------------------
// Learn: busy while, for each of the five channels, the mean is read, waited on,
// divided and written. Ask: busy while, per channel, the four class means are read,
// waited on and compared; the result strobe is registered from the done state.
// Clear: busy while all 20 means are zeroed. One request in flight at a time. Reset
// runs the same clearing pass, busy is high meanwhile. Results cannot be stalled.
module nearest_centroid_channel_classifier import ncc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_valid,
    output t_res o_res
);
    logic [SMP_W-1:0] mem [DEPTH];
    logic [SMP_W-1:0] rd_data;
    logic we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [SMP_W-1:0] wdata;

    t_state r_state, n_state;
    t_req r_req;
    logic [CNT_W-1:0] r_cnt [NUM_CLASSES];
    logic [CH_W-1:0] r_ch;
    logic [CLS_W-1:0] r_cls;
    logic [ADDR_W-1:0] r_clr;
    logic [SMP_W-1:0] r_best;
    logic [CLS_W-1:0] r_bcls;
    logic r_tie;
    logic [OUT_W-1:0] r_out [NUM_CHANNELS];
    logic [CNT_W-1:0] n_cur;
    logic div_start, div_done;
    logic [SMP_W-1:0] div_quo;
    logic [SMP_W-1:0] smp, diff;
    logic [29:0] acc;

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        rd_data <= mem[raddr];
    end

    assign smp = sample_sel(r_req, r_ch);
    assign diff = (smp >= rd_data) ? smp - rd_data : rd_data - smp;
    assign n_cur = r_cnt[r_req.class_index];
    assign acc = 30'(rd_data) * 30'(n_cur - 16'd1) + 30'(smp);
    assign raddr = ADDR_W'((r_state == S_LRD ? r_req.class_index : r_cls) * NUM_CHANNELS + r_ch);

    ncc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(acc), .i_den(n_cur), .o_done(div_done), .o_quo(div_quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (start) begin
                if (i_req.req_type == REQ_LEARN) n_state = S_LRD;
                else if (i_req.req_type == REQ_ASK) n_state = S_ARD;
                else if (i_req.req_type == REQ_CLEAR) n_state = S_CLEAR;
            end
            S_CLEAR: if (r_clr == ADDR_W'(DEPTH - 1)) n_state = S_IDLE;
            S_LRD:   n_state = S_LWAIT;
            S_LWAIT: n_state = S_LDIV;
            S_LDIV:  if (div_done) n_state = S_LWR;
            S_LWR:   n_state = (r_ch == CH_W'(NUM_CHANNELS - 1)) ? S_IDLE : S_LRD;
            S_ARD:   n_state = S_AWAIT;
            S_AWAIT: n_state = S_ACMP;
            S_ACMP:  if (r_cls == CLS_W'(NUM_CLASSES - 1))
                         n_state = (r_ch == CH_W'(NUM_CHANNELS - 1)) ? S_ADONE : S_ARD;
                     else n_state = S_ARD;
            S_ADONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy = (r_state != S_IDLE);
        div_start = (r_state == S_LWAIT);
        we = 1'b0;
        waddr = r_clr;
        wdata = '0;
        unique case (r_state)
            S_CLEAR: we = 1'b1;
            S_LWR: begin
                we = 1'b1;
                waddr = ADDR_W'(r_req.class_index * NUM_CHANNELS + r_ch);
                wdata = div_quo;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_ch <= '0;
            r_cls <= '0;
            o_valid <= 1'b0;
            for (int k = 0; k < NUM_CLASSES; k++) r_cnt[k] <= '0;
        end else begin
            r_state <= n_state;
            o_valid <= (r_state == S_ADONE);
            if (r_state == S_IDLE && start) begin
                r_req <= i_req;
                r_ch <= '0;
                r_cls <= '0;
                r_clr <= '0;
                if (i_req.req_type == REQ_LEARN && r_cnt[i_req.class_index] != COUNT_MAX)
                    r_cnt[i_req.class_index] <= r_cnt[i_req.class_index] + 16'd1;
                if (i_req.req_type == REQ_CLEAR)
                    for (int k = 0; k < NUM_CLASSES; k++) r_cnt[k] <= '0;
            end
            if (r_state == S_CLEAR) r_clr <= r_clr + ADDR_W'(1);
            if (r_state == S_LWR) r_ch <= r_ch + CH_W'(1);
            if (r_state == S_ACMP) begin
                r_cls <= r_cls + CLS_W'(1);
                if (r_cls == CLS_W'(NUM_CLASSES - 1)) r_ch <= r_ch + CH_W'(1);
            end
        end
    end

    // running minimum with tie tracking over classes of one channel
    always_ff @(posedge i_clk) begin
        if (r_state == S_ACMP) begin
            if (r_cls == '0 || diff < r_best) begin
                r_best <= diff;
                r_bcls <= r_cls;
                r_tie <= 1'b0;
                if (r_cls == CLS_W'(NUM_CLASSES - 1))
                    r_out[r_ch] <= (r_cls == '0) ? '0 : OUT_W'(r_cls);
            end else begin
                if (diff == r_best) r_tie <= 1'b1;
                if (r_cls == CLS_W'(NUM_CLASSES - 1))
                    r_out[r_ch] <= (diff == r_best || r_tie) ? NO_CLASS : OUT_W'(r_bcls);
            end
        end
    end

    assign o_res.nearest_ch0 = r_out[0];
    assign o_res.nearest_ch1 = r_out[1];
    assign o_res.nearest_ch2 = r_out[2];
    assign o_res.nearest_ch3 = r_out[3];
    assign o_res.nearest_ch4 = r_out[4];

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_ADONE)) else $error("stray result");
    a_div_in_learn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_LDIV) else $error("divider done outside learn");
    a_we_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> busy) else $error("write while idle");
endmodule
